// ===== hw/rtl/tdbv_pkg.sv =====
`default_nettype none

package tdbv_pkg;

  // Width of one stored word and of one CPU address
  localparam int DATA_W = 32;
  localparam int ADDR_W = 16;
  localparam int PIXEL_W = 15;

  // Command codes on the op port
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Lane masks that store something
  localparam logic [3:0] LANES_ALL   = 4'hF;
  localparam logic [3:0] LANES_UPPER = 4'hC;
  localparam logic [3:0] LANES_LOWER = 4'h3;

  // Transparency flag position inside each halfword
  localparam int UPPER_FLAG_BIT = 31;
  localparam int LOWER_FLAG_BIT = 15;

  // Store sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } store_state_t;

  // Access request from the command pipeline to the store
  typedef struct packed {
    logic rd;
    logic wr_hi;
    logic wr_lo;
    logic bank;
  } store_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tdbv_store.sv =====
`default_nettype none

module tdbv_store #(
  parameter int BUFFER_WORDS = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire tdbv_pkg::store_req_t             req,
  input  wire logic [$clog2(BUFFER_WORDS)-1:0]  offset,
  input  wire logic [tdbv_pkg::DATA_W-1:0]      wdata,
  output logic      [tdbv_pkg::DATA_W-1:0]      rdata,
  output logic                                  ready
);

  localparam int AW = $clog2(BUFFER_WORDS);
  localparam int HW = tdbv_pkg::DATA_W / 2;

  logic [tdbv_pkg::DATA_W-1:0] mem [2][BUFFER_WORDS];

  tdbv_pkg::store_state_t state;
  tdbv_pkg::store_state_t state_next;
  logic [AW-1:0]          clr_off;
  logic                   clr_bank;
  logic                   clr_last;

  assign clr_last = clr_bank && (clr_off == AW'(BUFFER_WORDS - 1));
  assign ready    = (state == tdbv_pkg::ST_RUN);

  // Leave the clearing pass after the last word of the second bank
  always_comb begin
    state_next = state;
    unique case (state)
      tdbv_pkg::ST_CLEAR: if (clr_last) state_next = tdbv_pkg::ST_RUN;
      tdbv_pkg::ST_RUN:   state_next = tdbv_pkg::ST_RUN;
      default:            state_next = tdbv_pkg::ST_CLEAR;
    endcase
  end

  // Advance the clear sweep one word per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tdbv_pkg::ST_CLEAR;
      clr_off  <= '0;
      clr_bank <= 1'b0;
    end else begin
      state <= state_next;
      if (state == tdbv_pkg::ST_CLEAR) begin
        if (clr_off == AW'(BUFFER_WORDS - 1)) begin
          clr_off  <= '0;
          clr_bank <= ~clr_bank;
        end else begin
          clr_off <= clr_off + 1'b1;
        end
      end
    end
  end

  // Clear, write halfwords, or read into the registered rdata
  always_ff @(posedge clk) begin
    if (state == tdbv_pkg::ST_CLEAR) begin
      mem[clr_bank][clr_off] <= '0;
    end else begin
      if (req.wr_hi) mem[req.bank][offset][2*HW-1:HW] <= wdata[2*HW-1:HW];
      if (req.wr_lo) mem[req.bank][offset][HW-1:0]    <= wdata[HW-1:0];
      if (req.rd)    rdata <= mem[req.bank][offset];
    end
  end

`ifndef ASSERT_OFF
  // No access may arrive while the sweep owns the memory
  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    !ready |-> !(req.rd || req.wr_hi || req.wr_lo))
    else $error("store access during clearing pass");

  // A read never shares a cycle with a write
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (rst)
    req.rd |-> !(req.wr_hi || req.wr_lo))
    else $error("store read and write in the same cycle");

  // Once cleared, the store stays ready
  a_ready_sticky: assert property (@(posedge clk) disable iff (rst)
    ready |=> ready)
    else $error("store left run state without reset");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/transparent_double_buffer_vram_core.sv =====
// Double-buffered video RAM core. One command (write, read or scan) is taken at
// every clock edge where start is high and busy is low, so the core sustains one
// command per clock. Each command produces exactly one result, marked by done:
// one register stage reduces the CPU address modulo the
// buffer size, the next accesses the synchronous memory. The receiver cannot
// stall and must take each result in the cycle where done is high. After reset
// busy stays high while the whole store, both banks, is swept to
// zero, one word per clock; after that busy stays low.
`default_nettype none

module transparent_double_buffer_vram_core #(
  parameter int BUFFER_WORDS   = 65536,
  parameter int VISIBLE_LINES  = 240,
  parameter int WORDS_PER_LINE = 160,
  parameter int ROW_STRIDE     = 168
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [1:0]                         op,
  input  wire logic [tdbv_pkg::ADDR_W-1:0]        word_address,
  input  wire logic [tdbv_pkg::DATA_W-1:0]        write_data,
  input  wire logic [3:0]                         lane_enable,
  input  wire logic                               buffer_sel,
  output logic                                    done,
  output logic      [tdbv_pkg::DATA_W-1:0]        read_data,
  output logic      [tdbv_pkg::PIXEL_W-1:0]       left_pixel,
  output logic      [tdbv_pkg::PIXEL_W-1:0]       right_pixel,
  output logic                                    line_done,
  output logic                                    frame_done
);

  localparam int AW  = $clog2(BUFFER_WORDS);
  localparam int CLW = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
  localparam int RLW = (VISIBLE_LINES > 1) ? $clog2(VISIBLE_LINES) : 1;
  localparam int STRIDE_MOD = ROW_STRIDE % BUFFER_WORDS;
  localparam longint unsigned RECIP = 64'h1_0000_0000 / BUFFER_WORDS;
  localparam int RECIP_W = $clog2(RECIP + 1);
  localparam int PW = tdbv_pkg::ADDR_W + RECIP_W;
  localparam int QW = (PW > 32) ? PW - 32 : 1;
  localparam int EW = (AW >= tdbv_pkg::ADDR_W) ? AW + 1 : tdbv_pkg::ADDR_W;
  localparam int HW = tdbv_pkg::DATA_W / 2;

  logic accept;
  logic store_ready;

  // Scan position
  logic [CLW-1:0] col;
  logic [RLW-1:0] row;
  logic [AW-1:0]  row_base;
  logic           scan_eol;
  logic           scan_eof;
  logic [AW:0]    scan_sum;
  logic [AW-1:0]  scan_off;
  logic [AW:0]    base_sum;
  logic [AW-1:0]  base_step;

  // Stage 1: command plus partial address reduction
  logic                        s1_valid;
  tdbv_pkg::op_t               s1_op;
  logic [tdbv_pkg::ADDR_W-1:0] s1_addr;
  logic [PW-1:0]               s1_prod;
  logic [tdbv_pkg::DATA_W-1:0] s1_data;
  logic [3:0]                  s1_lanes;
  logic                        s1_sel;
  logic [AW-1:0]               s1_scan_off;
  logic                        s1_eol;
  logic                        s1_eof;

  // Stage 2: memory access under way
  logic          s2_valid;
  tdbv_pkg::op_t s2_op;
  logic          s2_eol;
  logic          s2_eof;

  logic [QW-1:0]               quot;
  logic [EW-1:0]               rem_raw;
  logic [EW-1:0]               rem_fix;
  logic [AW-1:0]               cpu_off;
  logic                        is_scan;
  logic                        upper_opaque;
  logic                        lower_opaque;
  tdbv_pkg::store_req_t        req;
  logic [AW-1:0]               mem_off;
  logic [tdbv_pkg::DATA_W-1:0] rdata;

  assign busy   = !store_ready;
  assign accept = start && store_ready;

  // Form the scan offset and the next row base, each wrapped once
  assign scan_eol  = (col == CLW'(WORDS_PER_LINE - 1));
  assign scan_eof  = scan_eol && (row == RLW'(VISIBLE_LINES - 1));
  assign scan_sum  = {1'b0, row_base} + (AW + 1)'(col);
  assign scan_off  = (scan_sum >= (AW + 1)'(BUFFER_WORDS))
                   ? AW'(scan_sum - (AW + 1)'(BUFFER_WORDS)) : AW'(scan_sum);
  assign base_sum  = {1'b0, row_base} + (AW + 1)'(STRIDE_MOD);
  assign base_step = (base_sum >= (AW + 1)'(BUFFER_WORDS))
                   ? AW'(base_sum - (AW + 1)'(BUFFER_WORDS)) : AW'(base_sum);

  // Advance the raster walk on each scan transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      row_base <= '0;
    end else if (accept && (tdbv_pkg::op_t'(op) == tdbv_pkg::OP_SCAN)) begin
      if (scan_eol) begin
        col <= '0;
        if (scan_eof) begin
          row      <= '0;
          row_base <= '0;
        end else begin
          row      <= row + 1'b1;
          row_base <= base_step;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Capture the command and multiply the address by the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op       <= tdbv_pkg::op_t'(op);
      s1_addr     <= word_address;
      s1_prod     <= PW'(word_address) * PW'(RECIP);
      s1_data     <= write_data;
      s1_lanes    <= lane_enable;
      s1_sel      <= buffer_sel;
      s1_scan_off <= scan_off;
      s1_eol      <= scan_eol;
      s1_eof      <= scan_eof;
    end
  end

  // Finish the modulo: estimated quotient is exact or one short
  assign quot    = QW'(s1_prod >> 32);
  assign rem_raw = EW'(s1_addr) - EW'(quot) * EW'(BUFFER_WORDS);
  assign rem_fix = (rem_raw >= EW'(BUFFER_WORDS)) ? rem_raw - EW'(BUFFER_WORDS) : rem_raw;
  assign cpu_off = AW'(rem_fix);

  // Build the store request; transparent halfwords are dropped
  assign is_scan      = (s1_op == tdbv_pkg::OP_SCAN);
  assign upper_opaque = !s1_data[tdbv_pkg::UPPER_FLAG_BIT];
  assign lower_opaque = !s1_data[tdbv_pkg::LOWER_FLAG_BIT];
  assign mem_off      = is_scan ? s1_scan_off : cpu_off;

  always_comb begin
    req.bank  = s1_sel ^ is_scan;
    req.rd    = s1_valid && (is_scan || (s1_op == tdbv_pkg::OP_READ));
    req.wr_hi = s1_valid && (s1_op == tdbv_pkg::OP_WRITE) && upper_opaque
             && ((s1_lanes == tdbv_pkg::LANES_ALL) || (s1_lanes == tdbv_pkg::LANES_UPPER));
    req.wr_lo = s1_valid && (s1_op == tdbv_pkg::OP_WRITE) && lower_opaque
             && ((s1_lanes == tdbv_pkg::LANES_ALL) || (s1_lanes == tdbv_pkg::LANES_LOWER));
  end

  tdbv_store #(
    .BUFFER_WORDS (BUFFER_WORDS)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .offset (mem_off),
    .wdata  (s1_data),
    .rdata  (rdata),
    .ready  (store_ready)
  );

  // Hold the command tag alongside the memory read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_op  <= s1_op;
      s2_eol <= s1_eol;
      s2_eof <= s1_eof;
    end
  end

  // Drive the result for one cycle; unused fields read as zero
  assign done        = s2_valid;
  assign read_data   = (s2_valid && (s2_op == tdbv_pkg::OP_READ)) ? rdata : '0;
  assign left_pixel  = (s2_valid && (s2_op == tdbv_pkg::OP_SCAN))
                     ? rdata[HW + tdbv_pkg::PIXEL_W - 1:HW] : '0;
  assign right_pixel = (s2_valid && (s2_op == tdbv_pkg::OP_SCAN))
                     ? rdata[tdbv_pkg::PIXEL_W - 1:0] : '0;
  assign line_done   = s2_valid && (s2_op == tdbv_pkg::OP_SCAN) && s2_eol;
  assign frame_done  = s2_valid && (s2_op == tdbv_pkg::OP_SCAN) && s2_eof;

`ifndef ASSERT_OFF
  // Every transfer yields a result once it has passed stage 1 and stage 2
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##1 done)
    else $error("transfer without result");

  // No result without a transfer that passed stage 1 and stage 2 before it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 2))
    else $error("result without transfer");

  // End of frame is always also end of line
  a_frame_implies_line: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> line_done)
    else $error("frame_done without line_done");

  // The scan column stays within the line
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col <= CLW'(WORDS_PER_LINE - 1))
    else $error("scan column out of range");
`endif

endmodule

`default_nettype wire

// ===== bench/vram_shadow_checker.sv =====
`timescale 1ns / 100ps

module vram_shadow_checker #(
  parameter int BUFFER_WORDS   = 65536,
  parameter int VISIBLE_LINES  = 240,
  parameter int WORDS_PER_LINE = 160,
  parameter int ROW_STRIDE     = 168
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic [1:0]                   op,
  input  wire logic [tdbv_pkg::ADDR_W-1:0]  word_address,
  input  wire logic [tdbv_pkg::DATA_W-1:0]  write_data,
  input  wire logic [3:0]                   lane_enable,
  input  wire logic                         buffer_sel,
  input  wire logic                         done,
  input  wire logic [tdbv_pkg::DATA_W-1:0]  read_data,
  input  wire logic [tdbv_pkg::PIXEL_W-1:0] left_pixel,
  input  wire logic [tdbv_pkg::PIXEL_W-1:0] right_pixel,
  input  wire logic                         line_done,
  input  wire logic                         frame_done,
  output int                                fail_count,
  output int                                outstanding
);

  typedef struct packed {
    logic [tdbv_pkg::DATA_W-1:0]  read_data;
    logic [tdbv_pkg::PIXEL_W-1:0] left_pixel;
    logic [tdbv_pkg::PIXEL_W-1:0] right_pixel;
    logic                         line_done;
    logic                         frame_done;
  } vram_result_t;

  // Shadow copy of both buffers and of the raster cursor
  bit [tdbv_pkg::DATA_W-1:0] shadow_vram [2*BUFFER_WORDS];
  int unsigned               scan_col = 0;
  int unsigned               scan_line = 0;
  vram_result_t              expected_results [$];
  int                        mismatches = 0;

  assign fail_count = mismatches;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what,
                                 input logic [tdbv_pkg::DATA_W-1:0] got,
                                 input logic [tdbv_pkg::DATA_W-1:0] want);
    $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one command to the shadow state and return the result it yields
  function automatic vram_result_t predict_command(input tdbv_pkg::op_t cmd,
      input logic [tdbv_pkg::ADDR_W-1:0] addr, input logic [tdbv_pkg::DATA_W-1:0] data,
      input logic [3:0] lanes, input logic sel);
    vram_result_t res;
    int unsigned  cpu_idx;
    int unsigned  raster_idx;
    logic [tdbv_pkg::DATA_W-1:0] word;
    logic upper_opaque;
    logic lower_opaque;
    logic eol;
    logic eof;
    res = '0;
    cpu_idx = (sel ? BUFFER_WORDS : 0) + (int'(addr) % BUFFER_WORDS);
    case (cmd)
      tdbv_pkg::OP_WRITE: begin
        word = shadow_vram[cpu_idx];
        upper_opaque = !data[tdbv_pkg::UPPER_FLAG_BIT];
        lower_opaque = !data[tdbv_pkg::LOWER_FLAG_BIT];
        // Transparent halves keep the stored pixel
        if (lanes == tdbv_pkg::LANES_ALL) begin
          if (upper_opaque) word[31:16] = data[31:16];
          if (lower_opaque) word[15:0] = data[15:0];
        end else if (lanes == tdbv_pkg::LANES_UPPER && upper_opaque) begin
          word[31:16] = data[31:16];
        end else if (lanes == tdbv_pkg::LANES_LOWER && lower_opaque) begin
          word[15:0] = data[15:0];
        end
        shadow_vram[cpu_idx] = word;
      end
      tdbv_pkg::OP_READ: begin
        res.read_data = shadow_vram[cpu_idx];
      end
      tdbv_pkg::OP_SCAN: begin
        // Scan reads the buffer the CPU is not using
        raster_idx = (sel ? 0 : BUFFER_WORDS)
                   + ((scan_line * ROW_STRIDE + scan_col) % BUFFER_WORDS);
        word = shadow_vram[raster_idx];
        eol = (scan_col + 1 >= WORDS_PER_LINE);
        eof = eol && (scan_line + 1 >= VISIBLE_LINES);
        res.left_pixel  = word[30:16];
        res.right_pixel = word[14:0];
        res.line_done   = eol;
        res.frame_done  = eof;
        // Advance the raster cursor
        if (eol) begin
          scan_col  = 0;
          scan_line = eof ? 0 : scan_line + 1;
        end else begin
          scan_col++;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Compare each result with the oldest prediction, then record new transfers
  always @(posedge clk) begin : watch
    vram_result_t want;
    if (!rst) begin
      if (done !== 1'b0) begin
        if (expected_results.size() == 0) begin
          report_mismatch("done with nothing pending", {31'd0, done}, '0);
        end else begin
          want = expected_results.pop_front();
          if (read_data !== want.read_data)
            report_mismatch("read_data", read_data, want.read_data);
          if (left_pixel !== want.left_pixel)
            report_mismatch("left_pixel", tdbv_pkg::DATA_W'(left_pixel),
                            tdbv_pkg::DATA_W'(want.left_pixel));
          if (right_pixel !== want.right_pixel)
            report_mismatch("right_pixel", tdbv_pkg::DATA_W'(right_pixel),
                            tdbv_pkg::DATA_W'(want.right_pixel));
          if (line_done !== want.line_done)
            report_mismatch("line_done", tdbv_pkg::DATA_W'(line_done),
                            tdbv_pkg::DATA_W'(want.line_done));
          if (frame_done !== want.frame_done)
            report_mismatch("frame_done", tdbv_pkg::DATA_W'(frame_done),
                            tdbv_pkg::DATA_W'(want.frame_done));
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_command(tdbv_pkg::op_t'(op), word_address,
                                                   write_data, lane_enable, buffer_sel));
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int BUFFER_WORDS   = 65536;
  localparam int VISIBLE_LINES  = 240;
  localparam int WORDS_PER_LINE = 160;
  localparam int ROW_STRIDE     = 168;
  localparam int RANDOM_PER_PHASE = 600;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic [1:0]                   op = tdbv_pkg::OP_NONE;
  logic [tdbv_pkg::ADDR_W-1:0]  word_address = '0;
  logic [tdbv_pkg::DATA_W-1:0]  write_data = '0;
  logic [3:0]                   lane_enable = '0;
  logic                         buffer_sel = 1'b0;
  logic                         busy;
  logic                         done;
  logic [tdbv_pkg::DATA_W-1:0]  read_data;
  logic [tdbv_pkg::PIXEL_W-1:0] left_pixel;
  logic [tdbv_pkg::PIXEL_W-1:0] right_pixel;
  logic                         line_done;
  logic                         frame_done;
  int                           fail_count;
  int                           outstanding;

  int unsigned                  idle_pct;
  logic [tdbv_pkg::ADDR_W-1:0]  touched_addrs [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  transparent_double_buffer_vram_core #(
    .BUFFER_WORDS  (BUFFER_WORDS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .WORDS_PER_LINE(WORDS_PER_LINE),
    .ROW_STRIDE    (ROW_STRIDE)
  ) DUT (
    .clk, .rst, .start, .busy, .op, .word_address, .write_data, .lane_enable,
    .buffer_sel, .done, .read_data, .left_pixel, .right_pixel, .line_done, .frame_done
  );

  vram_shadow_checker #(
    .BUFFER_WORDS  (BUFFER_WORDS),
    .VISIBLE_LINES (VISIBLE_LINES),
    .WORDS_PER_LINE(WORDS_PER_LINE),
    .ROW_STRIDE    (ROW_STRIDE)
  ) checker_i (
    .clk, .rst, .start, .busy, .op, .word_address, .write_data, .lane_enable,
    .buffer_sel, .done, .read_data, .left_pixel, .right_pixel, .line_done, .frame_done,
    .fail_count, .outstanding
  );

  // Drive one command, with a random gap first, and hold it until the transfer
  task automatic send_cmd(input tdbv_pkg::op_t cmd, input logic [tdbv_pkg::ADDR_W-1:0] addr,
                          input logic [tdbv_pkg::DATA_W-1:0] data, input logic [3:0] lanes,
                          input logic sel);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    op           <= cmd;
    word_address <= addr;
    write_data   <= data;
    lane_enable  <= lanes;
    buffer_sel   <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Favor addresses already written or within the visible rows at the row stride
  function automatic logic [tdbv_pkg::ADDR_W-1:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35 && touched_addrs.size() > 0)
      return touched_addrs[$urandom_range(touched_addrs.size() - 1)];
    if (r < 70)
      return tdbv_pkg::ADDR_W'($urandom_range(VISIBLE_LINES - 1) * ROW_STRIDE
                               + $urandom_range(ROW_STRIDE - 1));
    return tdbv_pkg::ADDR_W'($urandom());
  endfunction

  task automatic send_random_cmd();
    int unsigned                 r;
    logic [tdbv_pkg::ADDR_W-1:0] addr;
    logic [3:0]                  lanes;
    r = $urandom_range(99);
    addr = pick_address();
    if ($urandom_range(1))
      lanes = ($urandom_range(2) == 0) ? tdbv_pkg::LANES_ALL :
              ($urandom_range(1) ? tdbv_pkg::LANES_UPPER : tdbv_pkg::LANES_LOWER);
    else
      lanes = 4'($urandom_range(15));
    if (r < 35) begin
      touched_addrs.push_back(addr);
      if (touched_addrs.size() > 32) void'(touched_addrs.pop_front());
      send_cmd(tdbv_pkg::OP_WRITE, addr, $urandom(), lanes, 1'($urandom_range(1)));
    end else if (r < 65) begin
      send_cmd(tdbv_pkg::OP_READ, addr, $urandom(), lanes, 1'($urandom_range(1)));
    end else if (r < 95) begin
      send_cmd(tdbv_pkg::OP_SCAN, addr, $urandom(), lanes, 1'($urandom_range(1)));
    end else begin
      send_cmd(tdbv_pkg::OP_NONE, addr, $urandom(), lanes, 1'($urandom_range(1)));
    end
  endtask

  // Stop a hung run
  initial begin
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    idle_pct = 29;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: lane masks, transparency, address extremes, both buffers
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0000, 32'h7FFF_1234, tdbv_pkg::LANES_ALL, 1'b1);
    send_cmd(tdbv_pkg::OP_SCAN, 16'h0000, 32'h0, 4'h0, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0001, 32'hFFFF_0ABC, tdbv_pkg::LANES_ALL, 1'b1);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0001, 32'h1111_8000, tdbv_pkg::LANES_ALL, 1'b1);
    send_cmd(tdbv_pkg::OP_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'hFFFF, 32'h7FFF_7FFF, tdbv_pkg::LANES_ALL, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, tdbv_pkg::LANES_ALL, 1'b0);
    send_cmd(tdbv_pkg::OP_READ, 16'hFFFF, 32'h0, 4'h0, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h1234_5678, tdbv_pkg::LANES_UPPER, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h8ABC_0DEF, tdbv_pkg::LANES_UPPER, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h0ABC_0DEF, tdbv_pkg::LANES_LOWER, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h7777_8001, tdbv_pkg::LANES_LOWER, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h5555_5555, 4'h5, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h2222_2222, 4'h0, 1'b0);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0002, 32'h3333_3333, 4'hE, 1'b0);
    send_cmd(tdbv_pkg::OP_READ, 16'h0002, 32'h0, 4'h0, 1'b0);
    send_cmd(tdbv_pkg::OP_READ, 16'h0002, 32'h0, 4'h0, 1'b1);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0004, 32'h8000_1111, tdbv_pkg::LANES_LOWER, 1'b1);
    send_cmd(tdbv_pkg::OP_WRITE, 16'h0004, 32'h2222_8000, tdbv_pkg::LANES_UPPER, 1'b1);
    send_cmd(tdbv_pkg::OP_READ, 16'h0004, 32'h0, 4'h0, 1'b1);
    send_cmd(tdbv_pkg::OP_NONE, 16'hA5A5, 32'hDEAD_BEEF, 4'hF, 1'b1);
    send_cmd(tdbv_pkg::OP_READ, 16'h0000, 32'h0, 4'h0, 1'b1);
    send_cmd(tdbv_pkg::OP_SCAN, 16'h0000, 32'h0, 4'h0, 1'b1);
    send_cmd(tdbv_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'hF, 1'b1);

    // Random traffic, sender gaps at 29 then 68 percent, then back to back
    repeat (RANDOM_PER_PHASE) send_random_cmd();
    idle_pct = 68;
    repeat (RANDOM_PER_PHASE) send_random_cmd();
    idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_cmd();

    repeat (40) send_random_cmd();
    start <= 1'b0;

    // Drain the pipeline
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== transparent_double_buffer_vram_core.f =====
hw/rtl/tdbv_pkg.sv
hw/rtl/tdbv_store.sv
hw/rtl/transparent_double_buffer_vram_core.sv
bench/vram_shadow_checker.sv
bench/testbench.sv
